// ----- src/nffs_pkg.sv -----
`default_nettype none
package nffs_pkg;

  localparam int EW = 13;           // size register / effective dimension width
  localparam int CW = 12;           // coordinate width
  localparam int PW = 32;           // pixel width
  localparam int RW = 2 * EW;       // render size width
  localparam int OW = RW + 1;       // signed offset width
  localparam int NW = RW + EW;      // scaled coordinate (dividend) width
  localparam int QW = EW;           // source coordinate quotient width
  localparam int IW = 3;            // config index width
  localparam int MAX_DIM = 4096;
  localparam int SOURCE_DEPTH_DEF = 65536;
  localparam int MQ_DEPTH = 4;
  localparam int OQ_DEPTH = 32;

  typedef enum logic [IW-1:0] {
    CFG_SW, CFG_SH, CFG_TW, CFG_TH, CFG_MODE, CFG_FLIP
  } cfg_idx_t;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_STRETCH = 2'd1;
  localparam logic [1:0] MODE_FIT     = 2'd2;
  localparam logic [1:0] MODE_FILL    = 2'd3;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {K_WR, K_MISS, K_HIT} kind_t;

  typedef enum logic [2:0] {G_IDLE, G_MUL, G_DIVA, G_DIVB, G_SEL} gstate_t;

  typedef struct packed {
    logic [EW-1:0]        sw;
    logic [EW-1:0]        sh;
    logic [EW-1:0]        tw;
    logic [EW-1:0]        th;
    logic [RW-1:0]        rw;
    logic [RW-1:0]        rh;
    logic signed [OW-1:0] offx;
    logic signed [OW-1:0] offy;
    logic                 flip;
    logic                 busy;
  } geom_t;

  typedef struct packed {
    kind_t         kind;
    logic [RW-1:0] a;
    logic [RW-1:0] b;
    logic [PW-1:0] pix;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  function automatic logic [EW-1:0] eff_dim(input logic [EW-1:0] v);
    logic [EW-1:0] r;
    r = v;
    if (v == '0) r = EW'(1);
    else if (v > EW'(MAX_DIM)) r = EW'(MAX_DIM);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/nearest_fit_fill_scaler_unit.sv -----
// channel   | ports                                              | transaction
// ----------+----------------------------------------------------+---------------------
// input     | in_push, in_full, in_command/coord_x/coord_y/rgba  | push && !full
// result    | out_empty, out_pop, out_pixel_argb, out_covered    | pop && !empty
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data          | valid && ready
//
// One item per cycle while in_full is low and the result queue has room; a read passes
// multiply, 13 quotient stages, row mirror, address and store read, result queue.
// After reset and after every config write the geometry unit runs a multiply and
// two serial divisions on one divider; in_full stays high meanwhile.
// Reads enter the back pipe only with room reserved in the 32-entry result queue.
`default_nettype none
module nearest_fit_fill_scaler_unit
  import nffs_pkg::*;
#(
  parameter int SOURCE_DEPTH = SOURCE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_command,
  input  wire logic [CW-1:0] in_coord_x,
  input  wire logic [CW-1:0] in_coord_y,
  input  wire logic [PW-1:0] in_pixel_rgba,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [PW-1:0]      out_pixel_argb,
  output logic               out_covered,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [IW-1:0] cfg_index,
  input  wire logic [EW-1:0] cfg_data
);
  geom_t geom;
  item_t fq_item, bq_item;
  logic  fq_push, mq_full, mq_empty, mq_pop;
  logic [$clog2(MQ_DEPTH):0] mq_count;
  logic [$clog2(OQ_DEPTH):0] oq_count;
  logic  oq_push, oq_full;
  logic [PW:0] oq_wdata, oq_rdata;

  assign cfg_ready = 1'b1;

  nffs_geom u_geom (
    .clk, .rst_n,
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_wdata(cfg_data),
    .geom
  );

  nffs_front u_front (
    .in_push, .in_command, .in_coord_x, .in_coord_y, .in_pixel_rgba,
    .geom,
    .q_full (mq_full),
    .in_full,
    .q_push (fq_push),
    .q_item (fq_item)
  );

  nffs_fifo #(.W(ITEM_W), .DEPTH(MQ_DEPTH)) u_mq (
    .clk, .rst_n,
    .push   (fq_push),
    .wr_data(fq_item),
    .pop    (mq_pop),
    .rd_data(bq_item),
    .empty  (mq_empty),
    .full   (mq_full),
    .count  (mq_count)
  );

  nffs_back #(.SOURCE_DEPTH(SOURCE_DEPTH)) u_back (
    .clk, .rst_n,
    .geom,
    .q_empty (mq_empty | (mq_count == '0)),
    .q_item  (bq_item),
    .q_pop   (mq_pop),
    .oq_count(oq_count),
    .oq_push (oq_push),
    .oq_data (oq_wdata)
  );

  nffs_fifo #(.W(PW+1), .DEPTH(OQ_DEPTH)) u_oq (
    .clk, .rst_n,
    .push   (oq_push && !oq_full),
    .wr_data(oq_wdata),
    .pop    (out_pop),
    .rd_data(oq_rdata),
    .empty  (out_empty),
    .full   (oq_full),
    .count  (oq_count)
  );

  assign out_pixel_argb = oq_rdata[PW:1];
  assign out_covered    = oq_rdata[0];
endmodule
`default_nettype wire

// ----- src/nffs_fifo.sv -----
`default_nettype none
module nffs_fifo
  import nffs_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [W-1:0]               wr_data,
  input  wire logic                       pop,
  output logic      [W-1:0]               rd_data,
  output logic                            empty,
  output logic                            full,
  output logic      [$clog2(DEPTH):0]     count
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign count   = cnt_r;
  assign rd_data = mem[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + AW'(1);
      if (do_pop) rp_r <= rp_r + AW'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + (AW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end
endmodule
`default_nettype wire

// ----- src/nffs_geom.sv -----
`default_nettype none
module nffs_geom
  import nffs_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [IW-1:0] cfg_idx,
  input  wire logic [EW-1:0] cfg_wdata,
  output geom_t              geom
);
  logic [EW-1:0] sw_raw_r, sh_raw_r, tw_raw_r, th_raw_r;
  logic [1:0]    mode_r;
  logic          flip_r;
  gstate_t       state_r, state_nxt;
  logic [RW-1:0] pb_r, num_r, a_r;
  logic [EW-1:0] rem_r;
  logic [$clog2(RW)-1:0] cnt_r;
  logic          wider_r;
  logic [RW-1:0] rw_r, rh_r;
  logic signed [OW-1:0] offx_r, offy_r;

  logic [EW-1:0] sw, sh, tw, th, dvs;
  logic [EW:0]   remsh;
  logic          qbit, last;
  logic [RW-1:0] b;

  assign sw = eff_dim(sw_raw_r);
  assign sh = eff_dim(sh_raw_r);
  assign tw = eff_dim(tw_raw_r);
  assign th = eff_dim(th_raw_r);

  // shared restoring divider: th*sw/sh first, then tw*sh/sw
  assign dvs   = (state_r == G_DIVA) ? sh : sw;
  assign remsh = {rem_r, num_r[RW-1]};
  assign qbit  = (remsh >= {1'b0, dvs});
  assign last  = (cnt_r == $clog2(RW)'(RW-1));
  assign b     = num_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      G_IDLE: state_nxt = G_IDLE;
      G_MUL:  state_nxt = G_DIVA;
      G_DIVA: if (last) state_nxt = G_DIVB;
      G_DIVB: if (last) state_nxt = G_SEL;
      G_SEL:  state_nxt = G_IDLE;
      default: state_nxt = G_MUL;
    endcase
    if (cfg_we) state_nxt = G_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= G_MUL;
      sw_raw_r <= EW'(1);
      sh_raw_r <= EW'(1);
      tw_raw_r <= EW'(1);
      th_raw_r <= EW'(1);
      mode_r   <= MODE_DEFAULT;
      flip_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SW:   sw_raw_r <= cfg_wdata;
          CFG_SH:   sh_raw_r <= cfg_wdata;
          CFG_TW:   tw_raw_r <= cfg_wdata;
          CFG_TH:   th_raw_r <= cfg_wdata;
          CFG_MODE: mode_r   <= cfg_wdata[1:0];
          CFG_FLIP: flip_r   <= cfg_wdata[0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      G_MUL: begin
        pb_r    <= tw * sh;
        num_r   <= th * sw;
        wider_r <= (RW'(sw) * RW'(th)) > (RW'(tw) * RW'(sh));
        rem_r   <= '0;
        cnt_r   <= '0;
      end
      G_DIVA, G_DIVB: begin
        rem_r <= qbit ? EW'(remsh - {1'b0, dvs}) : remsh[EW-1:0];
        num_r <= {num_r[RW-2:0], qbit};
        cnt_r <= cnt_r + $clog2(RW)'(1);
        if (last) begin
          rem_r <= '0;
          cnt_r <= '0;
          if (state_r == G_DIVA) begin
            a_r   <= {num_r[RW-2:0], qbit};
            num_r <= pb_r;
          end
        end
      end
      G_SEL: begin
        rw_r   <= RW'(tw);
        rh_r   <= RW'(th);
        offx_r <= '0;
        offy_r <= '0;
        if (mode_r == MODE_FILL) begin
          if (wider_r) begin
            rw_r   <= a_r;
            offx_r <= -$signed({1'b0, (a_r - RW'(tw)) >> 1});
          end else begin
            rh_r   <= b;
            offy_r <= -$signed({1'b0, (b - RW'(th)) >> 1});
          end
        end else if (mode_r != MODE_STRETCH) begin
          if (wider_r) begin
            rh_r   <= b;
            offy_r <= $signed({1'b0, (RW'(th) - b) >> 1});
          end else begin
            rw_r   <= a_r;
            offx_r <= $signed({1'b0, (RW'(tw) - a_r) >> 1});
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    geom.sw   = sw;
    geom.sh   = sh;
    geom.tw   = tw;
    geom.th   = th;
    geom.rw   = rw_r;
    geom.rh   = rh_r;
    geom.offx = offx_r;
    geom.offy = offy_r;
    geom.flip = flip_r;
    geom.busy = (state_r != G_IDLE);
  end
endmodule
`default_nettype wire

// ----- src/nffs_front.sv -----
`default_nettype none
module nffs_front
  import nffs_pkg::*;
(
  input  wire logic          in_push,
  input  wire logic          in_command,
  input  wire logic [CW-1:0] in_coord_x,
  input  wire logic [CW-1:0] in_coord_y,
  input  wire logic [PW-1:0] in_pixel_rgba,
  input  wire geom_t         geom,
  input  wire logic          q_full,
  output logic               in_full,
  output logic               q_push,
  output item_t              q_item
);
  logic                 accept, wr_ok, outside, hit;
  logic signed [OW-1:0] xs, ys;

  assign in_full = geom.busy || q_full;
  assign accept  = in_push && !in_full;

  assign wr_ok   = ({1'b0, in_coord_x} < geom.sw) && ({1'b0, in_coord_y} < geom.sh);
  assign outside = ({1'b0, in_coord_x} >= geom.tw) || ({1'b0, in_coord_y} >= geom.th);
  assign xs      = $signed(OW'(in_coord_x)) - geom.offx;
  assign ys      = $signed(OW'(in_coord_y)) - geom.offy;
  assign hit     = !outside && !xs[OW-1] && !ys[OW-1] &&
                   (xs[RW-1:0] < geom.rw) && (ys[RW-1:0] < geom.rh);

  always_comb begin
    q_item.pix = in_pixel_rgba;
    if (in_command == CMD_WRITE) begin
      q_item.kind = K_WR;
      q_item.a    = RW'(in_coord_x);
      q_item.b    = RW'(in_coord_y);
      q_push      = accept && wr_ok;
    end else begin
      q_item.kind = hit ? K_HIT : K_MISS;
      q_item.a    = xs[RW-1:0];
      q_item.b    = ys[RW-1:0];
      q_push      = accept;
    end
  end
endmodule
`default_nettype wire

// ----- src/nffs_back.sv -----
`default_nettype none
module nffs_back
  import nffs_pkg::*;
#(
  parameter int SOURCE_DEPTH = SOURCE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire geom_t                     geom,
  input  wire logic                      q_empty,
  input  wire item_t                     q_item,
  output logic                           q_pop,
  input  wire logic [$clog2(OQ_DEPTH):0] oq_count,
  output logic                           oq_push,
  output logic [PW:0]                    oq_data
);
  localparam int AW  = $clog2(SOURCE_DEPTH);
  localparam int ADW = 2 * EW + 1;
  localparam int NS  = QW + 1;
  localparam int CNW = $clog2(OQ_DEPTH) + 1;

  logic [PW-1:0] mem [SOURCE_DEPTH];

  logic [NS-1:0] v_r;
  kind_t         k_r  [NS];
  logic [NW-1:0] rx_r [NS];
  logic [NW-1:0] ry_r [NS];
  logic [EW-1:0] qx_r [NS];
  logic [EW-1:0] qy_r [NS];
  logic [PW-1:0] px_r [NS];

  logic          a_v_r, m_v_r, m_inr_r;
  kind_t         a_k_r, m_k_r;
  logic [EW-1:0] a_qx_r, a_qy_r;
  logic [PW-1:0] a_px_r, rd_r;

  logic [CNW-1:0] infl_r;
  logic           issue, issue_rd;
  logic [ADW-1:0] addr;
  logic           inr;

  // a read is only let in when the result queue is sure to have room for it
  assign issue    = !q_empty && ((CNW+1)'(oq_count) + (CNW+1)'(infl_r) < (CNW+1)'(OQ_DEPTH));
  assign q_pop    = issue;
  assign issue_rd = issue && (q_item.kind != K_WR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      a_v_r  <= 1'b0;
      m_v_r  <= 1'b0;
      infl_r <= '0;
    end else begin
      v_r   <= {v_r[NS-2:0], issue};
      a_v_r <= v_r[NS-1];
      m_v_r <= a_v_r;
      if (issue_rd && !oq_push) infl_r <= infl_r + CNW'(1);
      else if (oq_push && !issue_rd) infl_r <= infl_r - CNW'(1);
    end
  end

  // multiply, then one quotient bit per stage
  always_ff @(posedge clk) begin
    k_r[0]  <= q_item.kind;
    rx_r[0] <= q_item.a * geom.sw;
    ry_r[0] <= q_item.b * geom.sh;
    qx_r[0] <= (q_item.kind == K_WR) ? q_item.a[EW-1:0] : '0;
    qy_r[0] <= (q_item.kind == K_WR) ? q_item.b[EW-1:0] : '0;
    px_r[0] <= q_item.pix;
    for (int j = 1; j < NS; j++) begin
      k_r[j]  <= k_r[j-1];
      px_r[j] <= px_r[j-1];
      rx_r[j] <= rx_r[j-1];
      ry_r[j] <= ry_r[j-1];
      qx_r[j] <= qx_r[j-1];
      qy_r[j] <= qy_r[j-1];
      if (k_r[j-1] == K_HIT) begin
        if (rx_r[j-1] >= (NW'(geom.rw) << (QW - j))) begin
          rx_r[j]          <= rx_r[j-1] - (NW'(geom.rw) << (QW - j));
          qx_r[j][QW - j]  <= 1'b1;
        end
        if (ry_r[j-1] >= (NW'(geom.rh) << (QW - j))) begin
          ry_r[j]          <= ry_r[j-1] - (NW'(geom.rh) << (QW - j));
          qy_r[j][QW - j]  <= 1'b1;
        end
      end
    end
  end

  // row mirror
  always_ff @(posedge clk) begin
    a_k_r  <= k_r[NS-1];
    a_px_r <= px_r[NS-1];
    a_qx_r <= qx_r[NS-1];
    if (k_r[NS-1] == K_HIT && geom.flip) a_qy_r <= geom.sh - EW'(1) - qy_r[NS-1];
    else a_qy_r <= qy_r[NS-1];
  end

  assign addr = ADW'(a_qy_r * geom.sw) + ADW'(a_qx_r);
  assign inr  = (addr < ADW'(SOURCE_DEPTH));

  always_ff @(posedge clk) begin
    if (a_v_r && a_k_r == K_WR && inr) begin
      mem[addr[AW-1:0]] <= a_px_r;
    end
    rd_r    <= mem[addr[AW-1:0]];
    m_k_r   <= a_k_r;
    m_inr_r <= inr;
  end

  assign oq_push = m_v_r && (m_k_r != K_WR);

  always_comb begin
    oq_data = '0;
    if (m_k_r == K_HIT) begin
      oq_data[0] = 1'b1;
      if (m_inr_r) begin
        oq_data[PW:1] = {rd_r[31:24], rd_r[7:0], rd_r[15:8], rd_r[23:16]};
      end
    end
  end
endmodule
`default_nettype wire

// ----- bench/nffs_checker.sv -----
`timescale 1ns / 100ps
module nffs_checker
  import nffs_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_full,
  input  logic          in_command,
  input  logic [CW-1:0] in_coord_x,
  input  logic [CW-1:0] in_coord_y,
  input  logic [PW-1:0] in_pixel_rgba,
  input  logic          out_empty,
  input  logic          out_pop,
  input  logic [PW-1:0] out_pixel_argb,
  input  logic          out_covered,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [IW-1:0] cfg_index,
  input  logic [EW-1:0] cfg_data,
  output int            fail_count,
  output int            pixels_pending
);

  localparam int STORE_DEPTH = 65536;

  typedef struct {
    logic [PW-1:0] argb;
    logic          covered;
  } dest_pixel_t;

  logic [PW-1:0] src_image [STORE_DEPTH];
  logic [EW-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [1:0]    mode_r;
  logic          flip_r;
  dest_pixel_t   dest_q[$];

  assign pixels_pending = dest_q.size();

  function automatic longint clamp_dim(input logic [EW-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  function automatic dest_pixel_t scaled_pixel(input logic [CW-1:0] cx_in,
                                               input logic [CW-1:0] cy_in);
    dest_pixel_t r;
    longint sw, sh, tw, th, rw, rh, offx, offy, x, y, sx, sy, addr, cx, cy;
    logic [PW-1:0] p;
    bit wider;
    sw = clamp_dim(src_w_r);
    sh = clamp_dim(src_h_r);
    tw = clamp_dim(dst_w_r);
    th = clamp_dim(dst_h_r);
    cx = longint'(cx_in);
    cy = longint'(cy_in);
    r.argb = '0;
    r.covered = 1'b0;
    if (cx >= tw || cy >= th) return r;
    wider = sw * th > tw * sh;
    rw = tw;
    rh = th;
    offx = 0;
    offy = 0;
    if (mode_r == MODE_FILL) begin
      if (wider) begin
        rw = th * sw / sh;
        offx = -((rw - tw) / 2);
      end else begin
        rh = tw * sh / sw;
        offy = -((rh - th) / 2);
      end
    end else if (mode_r != MODE_STRETCH) begin
      if (wider) begin
        rh = tw * sh / sw;
        offy = (th - rh) / 2;
      end else begin
        rw = th * sw / sh;
        offx = (tw - rw) / 2;
      end
    end
    x = cx - offx;
    y = cy - offy;
    // bars, and an empty render, fall out here
    if (x < 0 || y < 0 || x >= rw || y >= rh) return r;
    sx = x * sw / rw;
    sy = y * sh / rh;
    if (flip_r) sy = (sy < sh) ? sh - 1 - sy : 0;
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    addr = sy * sw + sx;
    p = (addr < STORE_DEPTH) ? src_image[addr] : '0;
    r.argb = {p[31:24], p[7:0], p[15:8], p[23:16]};
    r.covered = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    longint addr;
    dest_pixel_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      src_w_r <= EW'(1);
      src_h_r <= EW'(1);
      dst_w_r <= EW'(1);
      dst_h_r <= EW'(1);
      mode_r  <= MODE_DEFAULT;
      flip_r  <= 1'b0;
      dest_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SW:   src_w_r <= cfg_data;
          CFG_SH:   src_h_r <= cfg_data;
          CFG_TW:   dst_w_r <= cfg_data;
          CFG_TH:   dst_h_r <= cfg_data;
          CFG_MODE: mode_r  <= cfg_data[1:0];
          CFG_FLIP: flip_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) begin
        if (in_command == CMD_WRITE) begin
          if (in_coord_x < clamp_dim(src_w_r) && in_coord_y < clamp_dim(src_h_r)) begin
            addr = longint'(in_coord_y) * clamp_dim(src_w_r) + longint'(in_coord_x);
            if (addr < STORE_DEPTH) src_image[addr] = in_pixel_rgba;
          end
        end else begin
          dest_q.push_back(scaled_pixel(in_coord_x, in_coord_y));
        end
      end
      if (out_pop && !out_empty) begin
        if (dest_q.size() == 0) begin
          $error("unexpected result transaction: argb=%h covered=%b",
                 out_pixel_argb, out_covered);
          errs++;
        end else begin
          e = dest_q.pop_front();
          if (out_pixel_argb !== e.argb) begin
            $error("pixel_argb: expected %h, got %h", e.argb, out_pixel_argb);
            errs++;
          end
          if (out_covered !== e.covered) begin
            $error("covered: expected %b, got %b", e.covered, out_covered);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import nffs_pkg::*;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  logic          in_full;
  logic          in_command = CMD_WRITE;
  logic [CW-1:0] in_coord_x = '0;
  logic [CW-1:0] in_coord_y = '0;
  logic [PW-1:0] in_pixel_rgba = '0;
  logic          out_empty;
  logic          out_pop = 1'b0;
  logic [PW-1:0] out_pixel_argb;
  logic          out_covered;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [EW-1:0] cfg_data = '0;

  int fail_count;
  int pixels_pending;
  int idle_pct = 10;
  int src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;

  always #1 clk = ~clk;

  nearest_fit_fill_scaler_unit uut (.*);
  nffs_checker chk (.*);

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // result side: random stalls
  always @(negedge clk) out_pop <= ($urandom_range(99) >= idle_pct);

  function automatic int eff_size(input int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  task automatic send_pixel_cmd(input logic cmd, input int x, input int y,
                                input logic [PW-1:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_command = cmd;
    in_coord_x = CW'(x);
    in_coord_y = CW'(y);
    in_pixel_rgba = pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = EW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      CFG_SW: src_w = eff_size(value);
      CFG_SH: src_h = eff_size(value);
      CFG_TW: dst_w = eff_size(value);
      CFG_TH: dst_h = eff_size(value);
      default: ;
    endcase
  endtask

  task automatic drain(input int tail);
    in_push = 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic set_geometry(input int sw, input int sh, input int tw, input int th,
                              input logic [1:0] mode, input logic flip);
    drain(30);
    write_reg(CFG_SW, sw);
    write_reg(CFG_SH, sh);
    write_reg(CFG_TW, tw);
    write_reg(CFG_TH, th);
    write_reg(CFG_MODE, int'(mode));
    write_reg(CFG_FLIP, int'(flip));
  endtask

  // every entry a read can reach gets written first
  task automatic load_source();
    for (int y = 0; y < src_h; y++)
      for (int x = 0; x < src_w; x++)
        send_pixel_cmd(CMD_WRITE, x, y, $urandom());
  endtask

  task automatic random_traffic(input int n, input int y_cap);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) begin
        if ($urandom_range(1)) begin
          x = $urandom_range(src_w - 1);
          y = $urandom_range(src_h - 1);
        end else begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
        end
        send_pixel_cmd(CMD_WRITE, x, y, $urandom());
      end else begin
        if ($urandom_range(99) < 85) begin
          x = $urandom_range(dst_w - 1);
          y = $urandom_range(dst_h - 1);
        end else begin
          x = $urandom_range(4095);
          y = $urandom_range(4095);
        end
        if (y > y_cap) y = y_cap;
        send_pixel_cmd(CMD_READ, x, y, $urandom());
      end
    end
  endtask

  initial begin
    int sw, sh, tw, th;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry: 1x1 onto 1x1
    send_pixel_cmd(CMD_WRITE, 0, 0, 32'hFFFF_FFFF);
    send_pixel_cmd(CMD_READ, 0, 0, '0);
    send_pixel_cmd(CMD_WRITE, 4095, 4095, 32'h1234_5678);  // outside source: dropped
    send_pixel_cmd(CMD_WRITE, 0, 0, 32'h0000_0000);
    send_pixel_cmd(CMD_READ, 0, 0, 32'hFFFF_FFFF);
    send_pixel_cmd(CMD_WRITE, 0, 0, 32'hA1B2_C3D4);
    send_pixel_cmd(CMD_READ, 0, 0, '0);
    send_pixel_cmd(CMD_READ, 4095, 0, '0);                  // outside target
    send_pixel_cmd(CMD_READ, 0, 4095, '0);
    send_pixel_cmd(CMD_READ, 4095, 4095, '0);

    // tiny source on the largest target; size registers 0 and above the cap
    set_geometry(0, 1, 8191, 4096, MODE_FIT, 1'b1);
    load_source();
    send_pixel_cmd(CMD_READ, 0, 0, '0);
    send_pixel_cmd(CMD_READ, 4095, 4095, '0);
    send_pixel_cmd(CMD_READ, 2048, 0, '0);

    // wide source fitted: letterbox bars, and fill crop
    set_geometry(8, 2, 4, 4, MODE_DEFAULT, 1'b0);
    load_source();
    for (int y = 0; y < 4; y++) send_pixel_cmd(CMD_READ, 1, y, '0);
    set_geometry(8, 2, 4, 4, MODE_FILL, 1'b1);
    load_source();
    send_pixel_cmd(CMD_READ, 0, 3, '0);
    send_pixel_cmd(CMD_READ, 3, 0, '0);
    // empty render: 1x16 source fitted into 16x1 floors to zero width
    set_geometry(1, 16, 16, 1, MODE_FIT, 1'b0);
    load_source();
    send_pixel_cmd(CMD_READ, 0, 0, '0);
    send_pixel_cmd(CMD_READ, 15, 0, '0);

    // store overflow: full-size source, reads land on mirrored rows past the store
    set_geometry(4096, 4096, 4096, 4096, MODE_STRETCH, 1'b1);
    random_traffic(60, 4079);

    for (int ph = 0; ph < 12; ph++) begin
      idle_pct = (ph == 3 || ph == 4) ? 0 : 10;
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 8);
      if ($urandom_range(1)) begin
        tw = $urandom_range(1, 16);
        th = $urandom_range(1, 16);
      end else begin
        tw = $urandom_range(1, 4096);
        th = $urandom_range(1, 4096);
      end
      if (ph == 6) tw = 0;
      if (ph == 7) th = 6000;
      set_geometry(sw, sh, tw, th, 2'($urandom_range(3)), 1'($urandom_range(1)));
      load_source();
      random_traffic(25, 4095);
      if (ph == 5) drain(0);
      random_traffic(25, 4095);
    end
    idle_pct = 10;

    drain(0);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pixels_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
